>>> design/dtq_pkg.sv
// ----------------------------------------------------------------------------
// Deadline timer queue package
// Widths, reset values and codes shared by the timer queue files.
// ----------------------------------------------------------------------------
package dtq_pkg;

   localparam int unsigned SLOTS      = 16;
   localparam int unsigned DEPTH_DEF  = 16;
   localparam int unsigned ID_W       = 4;
   localparam int unsigned TIME_W     = 52;
   localparam int unsigned RELOAD_W   = 32;
   localparam int unsigned MINR_W     = 8;
   localparam int unsigned KIND_W     = 2;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [RELOAD_W-1:0] MAX_RELOAD_RST = 32'h00ff_ffff;
   localparam logic [MINR_W-1:0]   MIN_RELOAD_RST = 8'd2;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_ARM     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_COMPARE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ    = 2'd2;

   // Response kinds.
   localparam logic [KIND_W-1:0] RK_EXPIRED = 2'd0;
   localparam logic [KIND_W-1:0] RK_RELOAD  = 2'd1;
   localparam logic [KIND_W-1:0] RK_IDLE    = 2'd2;
   localparam logic [KIND_W-1:0] RK_TIME    = 2'd3;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_MAX_RELOAD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_RELOAD = 1'd1;

endpackage

>>> design/dtq_if.sv
// ----------------------------------------------------------------------------
// Deadline timer queue channels
// Request, response and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface dtq_req_if;
   import dtq_pkg::*;
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [ID_W-1:0]     timer_id;
   logic [TIME_W-1:0]   deadline;
   logic [TIME_W-1:0]   raw_counter;
   modport source (output valid, kind, timer_id, deadline, raw_counter, input ready);
   modport sink   (input valid, kind, timer_id, deadline, raw_counter, output ready);
endinterface

interface dtq_rsp_if;
   import dtq_pkg::*;
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   result_kind;
   logic [ID_W-1:0]     expired_id;
   logic [TIME_W-1:0]   time_value;
   logic [RELOAD_W-1:0] reload_value;
   logic                last;
   modport source (output valid, result_kind, expired_id, time_value, reload_value, last,
                   input ready);
   modport sink   (input valid, result_kind, expired_id, time_value, reload_value, last,
                   output ready);
endinterface

interface dtq_csr_if;
   import dtq_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> design/deadline_timer_queue_core.sv
// ----------------------------------------------------------------------------
// Deadline timer queue core
// Keeps armed timers sorted by deadline and reports expiries and reloads.
// ----------------------------------------------------------------------------
// A request word carries a kind, a timer slot, a deadline and the raw 52-bit
// counter. The first request after reset latches the counter as the time
// base; every later time is the raw counter minus that base. An arm request
// removes the slot if it is armed and inserts it behind entries with an equal
// or earlier deadline, giving a reload word when it becomes the head. A
// compare request gives one expired word for each due entry, then a reload or
// an idle word. A read request gives the relative time. The final word caused
// by a request has last set.
// One request is handled at a time. The order list and the deadlines live in
// two memories with registered reads, so the cost is set by their walks: an
// arm walks the order list to remove an armed slot and again to insert it, and
// a compare shifts the list up once for each expired entry.
// Reset empties the queue and restores the register defaults; no clearing
// pass is needed. Results go through one output register; when the receiver
// stalls the walk waits in front of that register and no request is taken.
// Register writes are always accepted.
// ----------------------------------------------------------------------------
module deadline_timer_queue_core #(
   parameter int unsigned DEPTH = dtq_pkg::DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   dtq_req_if.sink     req_if,
   dtq_rsp_if.source   rsp_if,
   dtq_csr_if.sink     csr_if
);
   import dtq_pkg::*;

   localparam int unsigned IW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   typedef enum logic [14:0] {
      S_IDLE    = 15'h0001,
      S_RM_RD   = 15'h0002,
      S_RM_WR   = 15'h0004,
      S_INS_CHK = 15'h0008,
      S_INS_DL  = 15'h0010,
      S_INS_CMP = 15'h0020,
      S_INS_PUT = 15'h0040,
      S_HD_CHK  = 15'h0080,
      S_HD_DL   = 15'h0100,
      S_HD_CMP  = 15'h0200,
      S_SH_CHK  = 15'h0400,
      S_SH_WR   = 15'h0800,
      S_REL     = 15'h1000,
      S_CLAMP   = 15'h2000,
      S_EMIT    = 15'h4000
   } state_type;

   state_type state_ff, state_in;

   // Request context.
   logic [ID_W-1:0]     id_ff, id_in;
   logic [TIME_W-1:0]   dl_ff, dl_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   logic [TIME_W-1:0]   base_ff, base_in;
   logic                based_ff, based_in;

   // Queue control.
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [CW-1:0]       i_ff, i_in;
   logic [CW-1:0]       w_ff, w_in;
   logic [ID_W-1:0]     val_ff, val_in;
   logic [SLOTS-1:0]    armed_ff, armed_in;

   // Reload computation.
   logic [TIME_W-1:0]   hdl_ff, hdl_in;
   logic                lo_ff, lo_in;
   logic [TIME_W-1:0]   diff_ff, diff_in;
   logic [RELOAD_W-1:0] reload;

   // Pending word, waiting for the output register.
   logic [KIND_W-1:0]   pk_ff, pk_in;
   logic [ID_W-1:0]     pid_ff, pid_in;
   logic [TIME_W-1:0]   ptv_ff, ptv_in;
   logic [RELOAD_W-1:0] prv_ff, prv_in;
   logic                plast_ff, plast_in;

   // Registers.
   logic [RELOAD_W-1:0] max_ff, max_in;
   logic [MINR_W-1:0]   min_ff, min_in;

   // Output register.
   logic                ov_ff, ov_in;
   logic [KIND_W-1:0]   ok_ff, ok_in;
   logic [ID_W-1:0]     oid_ff, oid_in;
   logic [TIME_W-1:0]   otv_ff, otv_in;
   logic [RELOAD_W-1:0] orv_ff, orv_in;
   logic                olast_ff, olast_in;

   // Memories.
   logic [ID_W-1:0]     order_mem [DEPTH];
   logic [ID_W-1:0]     order_q;
   logic                ord_we;
   logic [IW-1:0]       ord_waddr, ord_raddr;
   logic [ID_W-1:0]     ord_wdata;
   logic [TIME_W-1:0]   dl_mem [SLOTS];
   logic [TIME_W-1:0]   dl_q;
   logic                dlm_we;
   logic [ID_W-1:0]     dlm_raddr;

   logic [CW-1:0]       im1;
   logic [TIME_W-1:0]   base_sel;
   logic                out_free;
   logic                accept;

   assign im1      = i_ff - CW'(1);
   assign out_free = !ov_ff || rsp_if.ready;
   assign accept   = req_if.valid && (state_ff == S_IDLE);
   assign base_sel = based_ff ? base_ff : req_if.raw_counter;

   assign req_if.ready = (state_ff == S_IDLE);
   assign csr_if.ready = 1'b1;

   dtq_reload u_reload (
      .below_min  (lo_ff),
      .delta      (diff_ff),
      .max_reload (max_ff),
      .min_reload (min_ff),
      .reload     (reload)
   );

   always_comb begin
      state_in  = state_ff;
      id_in     = id_ff;
      dl_in     = dl_ff;
      now_in    = now_ff;
      base_in   = base_ff;
      based_in  = based_ff;
      cnt_in    = cnt_ff;
      i_in      = i_ff;
      w_in      = w_ff;
      val_in    = val_ff;
      armed_in  = armed_ff;
      hdl_in    = hdl_ff;
      lo_in     = lo_ff;
      diff_in   = diff_ff;
      pk_in     = pk_ff;
      pid_in    = pid_ff;
      ptv_in    = ptv_ff;
      prv_in    = prv_ff;
      plast_in  = plast_ff;
      max_in    = max_ff;
      min_in    = min_ff;
      ov_in     = ov_ff && !rsp_if.ready;
      ok_in     = ok_ff;
      oid_in    = oid_ff;
      otv_in    = otv_ff;
      orv_in    = orv_ff;
      olast_in  = olast_ff;
      ord_we    = 1'b0;
      ord_waddr = i_ff[IW-1:0];
      ord_wdata = id_ff;
      ord_raddr = i_ff[IW-1:0];
      dlm_we    = 1'b0;
      dlm_raddr = order_q;

      if (csr_if.valid) begin
         case (csr_if.index)
            REG_MAX_RELOAD: max_in = csr_if.data;
            REG_MIN_RELOAD: min_in = csr_if.data[MINR_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               base_in  = base_sel;
               based_in = 1'b1;
               now_in   = req_if.raw_counter - base_sel;
               id_in    = req_if.timer_id;
               dl_in    = req_if.deadline;
               pid_in   = '0;
               ptv_in   = '0;
               prv_in   = '0;
               case (req_if.kind)
                  KIND_ARM: begin
                     if (armed_ff[req_if.timer_id]) begin
                        i_in     = '0;
                        w_in     = '0;
                        state_in = S_RM_RD;
                     end else if (cnt_ff >= CW'(DEPTH)) begin
                        // Full queue: the arm is dropped silently.
                        state_in = S_IDLE;
                     end else begin
                        i_in     = cnt_ff;
                        state_in = S_INS_CHK;
                     end
                  end
                  KIND_COMPARE: state_in = S_HD_CHK;
                  KIND_READ: begin
                     pk_in    = RK_TIME;
                     ptv_in   = req_if.raw_counter - base_sel;
                     plast_in = 1'b1;
                     state_in = S_EMIT;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end

         // Compact the order list, dropping the re-armed slot.
         S_RM_RD: begin
            ord_raddr = i_ff[IW-1:0];
            state_in  = S_RM_WR;
         end
         S_RM_WR: begin
            if (order_q != id_ff) begin
               ord_we    = 1'b1;
               ord_waddr = w_ff[IW-1:0];
               ord_wdata = order_q;
               w_in      = w_ff + CW'(1);
            end
            if (i_ff == cnt_ff - CW'(1)) begin
               cnt_in          = cnt_ff - CW'(1);
               armed_in[id_ff] = 1'b0;
               i_in            = cnt_ff - CW'(1);
               state_in        = S_INS_CHK;
            end else begin
               i_in     = i_ff + CW'(1);
               state_in = S_RM_RD;
            end
         end

         // Insert from the tail, moving later deadlines up one place.
         S_INS_CHK: begin
            ord_raddr = im1[IW-1:0];
            state_in  = (i_ff == '0) ? S_INS_PUT : S_INS_DL;
         end
         S_INS_DL: begin
            val_in    = order_q;
            dlm_raddr = order_q;
            state_in  = S_INS_CMP;
         end
         S_INS_CMP: begin
            if (dl_q > dl_ff) begin
               ord_we    = 1'b1;
               ord_wdata = val_ff;
               i_in      = im1;
               state_in  = S_INS_CHK;
            end else begin
               state_in  = S_INS_PUT;
            end
         end
         S_INS_PUT: begin
            ord_we          = 1'b1;
            ord_wdata       = id_ff;
            dlm_we          = 1'b1;
            armed_in[id_ff] = 1'b1;
            cnt_in          = cnt_ff + CW'(1);
            hdl_in          = dl_ff;
            state_in        = (i_ff == '0) ? S_REL : S_IDLE;
         end

         // Expiry walk over the head of the queue.
         S_HD_CHK: begin
            ord_raddr = '0;
            if (cnt_ff == '0) begin
               pk_in    = RK_IDLE;
               pid_in   = '0;
               ptv_in   = '0;
               prv_in   = '0;
               plast_in = 1'b1;
               state_in = S_EMIT;
            end else begin
               state_in = S_HD_DL;
            end
         end
         S_HD_DL: begin
            val_in    = order_q;
            dlm_raddr = order_q;
            state_in  = S_HD_CMP;
         end
         S_HD_CMP: begin
            if (dl_q <= now_ff) begin
               armed_in[val_ff] = 1'b0;
               pk_in    = RK_EXPIRED;
               pid_in   = val_ff;
               ptv_in   = dl_q;
               prv_in   = '0;
               plast_in = 1'b0;
               state_in = S_EMIT;
            end else begin
               hdl_in   = dl_q;
               state_in = S_REL;
            end
         end
         S_SH_CHK: begin
            ord_raddr = i_ff[IW-1:0];
            if (i_ff == cnt_ff) begin
               cnt_in   = cnt_ff - CW'(1);
               state_in = S_HD_CHK;
            end else begin
               state_in = S_SH_WR;
            end
         end
         S_SH_WR: begin
            ord_we    = 1'b1;
            ord_waddr = im1[IW-1:0];
            ord_wdata = order_q;
            i_in      = i_ff + CW'(1);
            state_in  = S_SH_CHK;
         end

         // Reload: compare against the lower bound, then clamp.
         S_REL: begin
            lo_in    = {1'b0, hdl_ff} < ({1'b0, now_ff} + (TIME_W + 1)'(min_ff));
            diff_in  = hdl_ff - now_ff;
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            pk_in    = RK_RELOAD;
            pid_in   = '0;
            ptv_in   = '0;
            prv_in   = reload;
            plast_in = 1'b1;
            state_in = S_EMIT;
         end

         S_EMIT: begin
            if (out_free) begin
               ov_in    = 1'b1;
               ok_in    = pk_ff;
               oid_in   = pid_ff;
               otv_in   = ptv_ff;
               orv_in   = prv_ff;
               olast_in = plast_ff;
               if (plast_ff) begin
                  state_in = S_IDLE;
               end else begin
                  i_in     = CW'(1);
                  state_in = S_SH_CHK;
               end
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         based_ff <= 1'b0;
         base_ff  <= '0;
         cnt_ff   <= '0;
         armed_ff <= '0;
         max_ff   <= MAX_RELOAD_RST;
         min_ff   <= MIN_RELOAD_RST;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         based_ff <= based_in;
         base_ff  <= base_in;
         cnt_ff   <= cnt_in;
         armed_ff <= armed_in;
         max_ff   <= max_in;
         min_ff   <= min_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff    <= id_in;
      dl_ff    <= dl_in;
      now_ff   <= now_in;
      i_ff     <= i_in;
      w_ff     <= w_in;
      val_ff   <= val_in;
      hdl_ff   <= hdl_in;
      lo_ff    <= lo_in;
      diff_ff  <= diff_in;
      pk_ff    <= pk_in;
      pid_ff   <= pid_in;
      ptv_ff   <= ptv_in;
      prv_ff   <= prv_in;
      plast_ff <= plast_in;
      ok_ff    <= ok_in;
      oid_ff   <= oid_in;
      otv_ff   <= otv_in;
      orv_ff   <= orv_in;
      olast_ff <= olast_in;
   end

   // Order list memory.
   always_ff @(posedge clock) begin
      if (ord_we) begin
         order_mem[ord_waddr] <= ord_wdata;
      end
      order_q <= order_mem[ord_raddr];
   end

   // Deadline memory, one entry per timer slot.
   always_ff @(posedge clock) begin
      if (dlm_we) begin
         dl_mem[id_ff] <= dl_ff;
      end
      dl_q <= dl_mem[dlm_raddr];
   end

   assign rsp_if.valid        = ov_ff;
   assign rsp_if.result_kind  = ok_ff;
   assign rsp_if.expired_id   = oid_ff;
   assign rsp_if.time_value   = otv_ff;
   assign rsp_if.reload_value = orv_ff;
   assign rsp_if.last         = olast_ff;

endmodule

>>> design/dtq_reload.sv
// ----------------------------------------------------------------------------
// Reload clamp
// Clamps the distance to the head deadline into [min_reload, max_reload].
// ----------------------------------------------------------------------------
module dtq_reload (
   input  logic                          below_min,
   input  logic [dtq_pkg::TIME_W-1:0]    delta,
   input  logic [dtq_pkg::RELOAD_W-1:0]  max_reload,
   input  logic [dtq_pkg::MINR_W-1:0]    min_reload,
   output logic [dtq_pkg::RELOAD_W-1:0]  reload
);
   import dtq_pkg::*;

   // The lower bound wins when the two bounds cross.
   always_comb begin
      if (below_min) begin
         reload = RELOAD_W'(min_reload);
      end else if (delta > TIME_W'(max_reload)) begin
         reload = max_reload;
      end else begin
         reload = delta[RELOAD_W-1:0];
      end
   end

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// Deadline timer queue testbench
// Drives arm, compare and read words into the timer queue core, predicts
// every response word from a model of the sorted queue kept here, and checks
// each response field by field. Register writes happen only while idle.
// ----------------------------------------------------------------------------
module tb_top;
   import dtq_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 2000000;
   localparam logic [TIME_W-1:0] T_MAX = {TIME_W{1'b1}};

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [ID_W-1:0]     id;
      logic [TIME_W-1:0]   dl;
      logic [TIME_W-1:0]   raw;
   } req_t;

   typedef struct packed {
      logic [KIND_W-1:0]   rk;
      logic [ID_W-1:0]     id;
      logic [TIME_W-1:0]   tv;
      logic [RELOAD_W-1:0] rv;
      logic                last;
   } rsp_t;

   // A directed row: the request, plus an optional typed-in expected word.
   typedef struct packed {
      req_t r;
      logic has_exp;
      rsp_t e;
   } row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dtq_req_if req_if ();
   dtq_rsp_if rsp_if ();
   dtq_csr_if csr_if ();

   deadline_timer_queue_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source),
      .csr_if (csr_if.sink)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predictor state: our own copy of the queue and the registers.
   logic [TIME_W-1:0]   slot_dl [SLOTS];
   logic                slot_armed [SLOTS];
   logic [ID_W-1:0]     queue_ids [$];
   logic [TIME_W-1:0]   time_base;
   logic                base_taken;
   logic [RELOAD_W-1:0] reg_max;
   logic [MINR_W-1:0]   reg_min;

   rsp_t pending_words [$];
   int   mismatches = 0;
   int   cycles = 0;

   function automatic logic [RELOAD_W-1:0] clamp_reload(logic [TIME_W-1:0] dl,
                                                        logic [TIME_W-1:0] now);
      logic [TIME_W+1:0] diff;
      diff = {2'b00, dl} - {2'b00, now};
      // The lower clamp is tested first, so it wins on crossed limits.
      if ({1'b0, dl} < {1'b0, now} + reg_min) return {24'd0, reg_min};
      if (diff > reg_max) return reg_max;
      return diff[RELOAD_W-1:0];
   endfunction

   function automatic rsp_t mk(logic [KIND_W-1:0] rk, logic [ID_W-1:0] id,
                               logic [TIME_W-1:0] tv, logic [RELOAD_W-1:0] rv);
      rsp_t w;
      w.rk = rk; w.id = id; w.tv = tv; w.rv = rv; w.last = 1'b0;
      return w;
   endfunction

   // Works out the words that one request causes and updates the model.
   task automatic predict_words(input req_t r, output rsp_t ws [$]);
      logic [TIME_W-1:0] now;
      int pos;
      logic [ID_W-1:0] h;
      ws = {};
      if (!base_taken) begin
         time_base = r.raw;
         base_taken = 1'b1;
      end
      now = r.raw - time_base;
      if (r.kind == KIND_ARM) begin
         if (slot_armed[r.id]) begin
            slot_armed[r.id] = 1'b0;
            foreach (queue_ids[i])
               if (queue_ids[i] == r.id) begin
                  queue_ids.delete(i);
                  break;
               end
         end
         pos = 0;
         while (pos < queue_ids.size() && slot_dl[queue_ids[pos]] <= r.dl) pos++;
         queue_ids.insert(pos, r.id);
         slot_dl[r.id] = r.dl;
         slot_armed[r.id] = 1'b1;
         if (pos == 0) ws.push_back(mk(RK_RELOAD, '0, '0, clamp_reload(r.dl, now)));
      end else if (r.kind == KIND_COMPARE) begin
         while (queue_ids.size() > 0 && slot_dl[queue_ids[0]] <= now) begin
            h = queue_ids.pop_front();
            slot_armed[h] = 1'b0;
            ws.push_back(mk(RK_EXPIRED, h, slot_dl[h], '0));
         end
         if (queue_ids.size() > 0)
            ws.push_back(mk(RK_RELOAD, '0, '0, clamp_reload(slot_dl[queue_ids[0]], now)));
         else
            ws.push_back(mk(RK_IDLE, '0, '0, '0));
      end else if (r.kind == KIND_READ) begin
         ws.push_back(mk(RK_TIME, '0, now, '0));
      end
      if (ws.size() > 0) ws[ws.size()-1].last = 1'b1;
   endtask

   // Sender: one request word, after a random gap with valid low. The
   // word stays valid until the next request or the next drain takes over.
   task automatic send_request(input req_t r, input logic has_exp, input rsp_t e);
      rsp_t ws [$];
      int gap;
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      predict_words(r, ws);
      // A typed-in row must agree with the predictor as well.
      if (has_exp && (ws.size() != 1 || ws[0] != e)) begin
         mismatches++;
         if (mismatches <= 10)
            $display("directed row disagrees: typed %h predicted %p", e, ws);
      end
      foreach (ws[i]) pending_words.push_back(has_exp ? e : ws[i]);
      req_if.kind <= r.kind;
      req_if.timer_id <= r.id;
      req_if.deadline <= r.dl;
      req_if.raw_counter <= r.raw;
      req_if.valid <= 1'b1;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] v);
      csr_if.index <= idx;
      csr_if.data <= v;
      csr_if.valid <= 1'b1;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      if (idx == REG_MAX_RELOAD) reg_max = v;
      else reg_min = v[MINR_W-1:0];
      @(negedge clock);
      csr_if.valid <= 1'b0;
      @(negedge clock);
   endtask

   // Wait until every expected word has arrived, then let the walk settle.
   task automatic drain;
      req_if.valid <= 1'b0;
      while (pending_words.size() > 0) @(negedge clock);
      repeat (120) @(negedge clock);
   endtask

   // Receiver: a random stall with ready low before each word is taken.
   initial begin
      int stall;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      forever begin
         stall = $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
         if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word kind %0d", rsp_if.result_kind);
         end else begin
            rsp_t e;
            e = pending_words.pop_front();
            if (rsp_if.result_kind !== e.rk || rsp_if.expired_id !== e.id ||
                rsp_if.time_value !== e.tv || rsp_if.reload_value !== e.rv ||
                rsp_if.last !== e.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("word mismatch: expected %0d/%0d/%h/%h/%0d got %0d/%0d/%h/%h/%0d",
                           e.rk, e.id, e.tv, e.rv, e.last, rsp_if.result_kind,
                           rsp_if.expired_id, rsp_if.time_value, rsp_if.reload_value,
                           rsp_if.last);
            end
         end
         @(negedge clock);
      end
   end

   // Cycle counter guarding against a hang.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   function automatic req_t mkreq(logic [KIND_W-1:0] k, logic [ID_W-1:0] id,
                                  logic [TIME_W-1:0] dl, logic [TIME_W-1:0] raw);
      req_t r;
      r.kind = k; r.id = id; r.dl = dl; r.raw = raw;
      return r;
   endfunction

   // Main sequence.
   initial begin
      row_t table_rows [$];
      row_t row;
      rsp_t none;
      req_t r;
      logic [TIME_W-1:0] now_raw;
      logic [TIME_W-1:0] base_raw;
      int sel;
      none = '0;
      req_if.valid = 1'b0;
      req_if.kind = KIND_READ;
      req_if.timer_id = '0;
      req_if.deadline = '0;
      req_if.raw_counter = '0;
      csr_if.valid = 1'b0;
      csr_if.index = REG_MAX_RELOAD;
      csr_if.data = '0;
      foreach (slot_armed[i]) begin
         slot_armed[i] = 1'b0;
         slot_dl[i] = '0;
      end
      base_taken = 1'b0;
      time_base = '0;
      reg_max = MAX_RELOAD_RST;
      reg_min = MIN_RELOAD_RST;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table. The first word latches the base, so reading at the
      // same raw value gives zero; a compare on an empty queue is idle.
      base_raw = 52'h1000;
      table_rows.push_back('{mkreq(KIND_READ, 4'd0, '0, base_raw), 1'b1,
                             mk(RK_TIME, '0, '0, '0) | rsp_t'(1)});
      table_rows.push_back('{mkreq(KIND_COMPARE, 4'd0, '0, base_raw), 1'b1,
                             mk(RK_IDLE, '0, '0, '0) | rsp_t'(1)});
      // Deadline already due: reload clamps to the minimum.
      table_rows.push_back('{mkreq(KIND_ARM, 4'd15, '0, base_raw + 5), 1'b1,
                             mk(RK_RELOAD, '0, '0, 32'd2) | rsp_t'(1)});
      // Far deadline, not the head: no word at all.
      table_rows.push_back('{mkreq(KIND_ARM, 4'd0, T_MAX, base_raw + 5), 1'b0, none});
      // Equal deadline goes behind; then re-arm slot 15 far away.
      table_rows.push_back('{mkreq(KIND_ARM, 4'd3, '0, base_raw + 6), 1'b0, none});
      table_rows.push_back('{mkreq(KIND_ARM, 4'd15, 52'd100, base_raw + 6), 1'b0, none});
      table_rows.push_back('{mkreq(KIND_COMPARE, 4'd0, '0, base_raw + 50), 1'b0, none});
      table_rows.push_back('{mkreq(KIND_COMPARE, 4'd0, '0, base_raw + 100), 1'b0, none});
      // Head far away: reload clamps to the maximum.
      table_rows.push_back('{mkreq(KIND_COMPARE, 4'd0, '0, base_raw + 200), 1'b1,
                             mk(RK_RELOAD, '0, '0, MAX_RELOAD_RST) | rsp_t'(1)});
      // Counter below the base wraps.
      table_rows.push_back('{mkreq(KIND_READ, 4'd0, '0, '0), 1'b1,
                             mk(RK_TIME, '0, -base_raw, '0) | rsp_t'(1)});
      table_rows.push_back('{mkreq(KIND_READ, 4'd0, '0, T_MAX), 1'b0, none});
      // Kind 3 is ignored.
      table_rows.push_back('{mkreq(2'd3, 4'd9, T_MAX, T_MAX), 1'b0, none});
      table_rows.push_back('{mkreq(KIND_ARM, 4'd0, 52'd300, base_raw + 250), 1'b0, none});
      table_rows.push_back('{mkreq(KIND_COMPARE, 4'd0, '0, T_MAX), 1'b0, none});
      foreach (table_rows[i]) begin
         row = table_rows[i];
         send_request(row.r, row.has_exp, row.e);
      end
      drain();

      // Random phases under a range of register settings, extremes included.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin write_reg(REG_MAX_RELOAD, 32'd2); write_reg(REG_MIN_RELOAD, 32'd1); end
            1: begin write_reg(REG_MAX_RELOAD, 32'hffff_ffff); write_reg(REG_MIN_RELOAD, 32'd255); end
            2: begin write_reg(REG_MAX_RELOAD, 32'd100); write_reg(REG_MIN_RELOAD, 32'd200); end
            default: begin
               write_reg(REG_MAX_RELOAD, $urandom_range(2, 5000));
               write_reg(REG_MIN_RELOAD, $urandom_range(1, 255));
            end
         endcase
         now_raw = base_raw + phase * 52'h10000;
         for (int n = 0; n < 60; n++) begin
            sel = $urandom_range(0, 99);
            now_raw = now_raw + TIME_W'($urandom_range(0, 400));
            if (sel < 55)
               r = mkreq(KIND_ARM, ID_W'($urandom_range(0, 15)),
                         (now_raw - base_raw) + TIME_W'($urandom_range(0, 3000))
                         - TIME_W'(200), now_raw);
            else if (sel < 85)
               r = mkreq(KIND_COMPARE, ID_W'($urandom_range(0, 15)), '0, now_raw);
            else if (sel < 93)
               r = mkreq(KIND_READ, ID_W'($urandom_range(0, 15)), '0, now_raw);
            else
               // Noise: full-width random fields to toggle every bit.
               r = mkreq(KIND_W'($urandom_range(0, 3)), ID_W'($urandom_range(0, 15)),
                         TIME_W'({$urandom(), $urandom()}),
                         TIME_W'({$urandom(), $urandom()}));
            send_request(r, 1'b0, none);
         end
         drain();
      end

      if (mismatches == 0 && pending_words.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/dtq_pkg.sv
design/dtq_if.sv
design/dtq_reload.sv
design/deadline_timer_queue_core.sv
bench/tb_top.sv
